FILE: design/bcpd_pkg.sv
package bcpd_pkg;

  localparam int TIME_BITS = 32;

  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_PRESSED_LEVEL = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE_MS   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_PRESS_MS = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLICK_GAP_MS  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_CLICKS    = 3'd4;

  localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [15:0] LONG_PRESS_RST = 16'd800;
  localparam logic [15:0] CLICK_GAP_RST  = 16'd400;
  localparam logic [3:0]  MAX_CLICKS_RST = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_DOWN     = 3'd1,
    ST_UP       = 3'd2,
    ST_COUNT    = 3'd3,
    ST_PRESS    = 3'd4,
    ST_RELEASED = 3'd5
  } state_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_CLICK  = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_TRIPLE = 3'd3,
    EV_LONG   = 3'd4
  } event_t;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef struct packed {
    logic        pin_level;
    logic [31:0] now_ms;
    logic        clear_event;
  } sample_t;

  typedef struct packed {
    logic        pressed_level;
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
    logic [15:0] click_gap_ms;
    logic [3:0]  max_clicks;
  } cfg_t;

endpackage

FILE: design/bcpd_fsm.sv
module bcpd_fsm
  import bcpd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  sample_t smp,
  input  cfg_t    cfg,
  output event_t  event_nxt
);

  state_t      state_r, state_nxt;
  state_t      prev_r, prev_nxt;
  time_t       start_r, start_nxt;
  logic [3:0]  count_r, count_nxt;
  event_t      event_r;

  logic   active;
  time_t  now_t;
  time_t  wait_t;
  logic   short_wait;
  logic   go_idle;
  event_t ev_base;

  assign active     = (smp.pin_level == cfg.pressed_level);
  assign now_t      = TIME_BITS'(smp.now_ms);
  assign wait_t     = now_t - start_r;
  assign short_wait = (wait_t < TIME_BITS'(cfg.debounce_ms));
  assign ev_base    = smp.clear_event ? EV_NONE : event_r;

  // burst closes on a quiet gap or once the click limit is reached, or when a long press release settles
  assign go_idle = (state_r == ST_COUNT && !active &&
                    (wait_t > TIME_BITS'(cfg.click_gap_ms) || count_r == cfg.max_clicks)) ||
                   (state_r == ST_RELEASED && !(active && short_wait) && !short_wait);

  // next state
  always_comb begin
    state_nxt = state_r;
    prev_nxt  = prev_r;
    unique case (state_r)
      ST_IDLE: begin
        if (active) begin
          state_nxt = ST_DOWN;
          prev_nxt  = state_r;
        end
      end
      ST_DOWN: begin
        if (!active && short_wait) begin
          state_nxt = prev_r;
          prev_nxt  = state_r;
        end else if (!active) begin
          state_nxt = ST_UP;
          prev_nxt  = state_r;
        end else if (wait_t > TIME_BITS'(cfg.long_press_ms)) begin
          state_nxt = ST_PRESS;
          prev_nxt  = state_r;
        end
      end
      ST_UP, ST_RELEASED: begin
        if (active && short_wait) begin
          state_nxt = prev_r;
          prev_nxt  = state_r;
        end else if (!short_wait) begin
          if (state_r == ST_UP) begin
            state_nxt = ST_COUNT;
            prev_nxt  = state_r;
          end else begin
            state_nxt = ST_IDLE;
            prev_nxt  = ST_IDLE;
          end
        end
      end
      ST_COUNT: begin
        if (active) begin
          state_nxt = ST_DOWN;
          prev_nxt  = state_r;
        end else if (go_idle) begin
          state_nxt = ST_IDLE;
          prev_nxt  = ST_IDLE;
        end
      end
      ST_PRESS: begin
        if (!active) begin
          state_nxt = ST_RELEASED;
          prev_nxt  = state_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        prev_nxt  = state_r;
      end
    endcase
  end

  // timestamp, click count and event
  always_comb begin
    start_nxt = start_r;
    count_nxt = count_r;
    event_nxt = ev_base;
    if (go_idle) begin
      start_nxt = '0;
      count_nxt = '0;
      if (state_r == ST_RELEASED) begin
        event_nxt = EV_LONG;
      end else begin
        unique case (count_r)
          4'd1:    event_nxt = EV_CLICK;
          4'd2:    event_nxt = EV_DOUBLE;
          4'd3:    event_nxt = EV_TRIPLE;
          default: event_nxt = ev_base;
        endcase
      end
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (active) begin
            start_nxt = now_t;
            count_nxt = '0;
          end
        end
        ST_DOWN: begin
          if (!active && !short_wait) begin
            start_nxt = now_t;
          end
        end
        ST_UP: begin
          if (!(active && short_wait) && !short_wait) begin
            count_nxt = count_r + 4'd1;
          end
        end
        ST_COUNT: begin
          if (active) begin
            start_nxt = now_t;
          end
        end
        ST_PRESS: begin
          if (!active) begin
            start_nxt = now_t;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      prev_r  <= ST_IDLE;
      start_r <= '0;
      count_r <= '0;
      event_r <= EV_NONE;
    end else if (step) begin
      state_r <= state_nxt;
      prev_r  <= prev_nxt;
      start_r <= start_nxt;
      count_r <= count_nxt;
      event_r <= event_nxt;
    end
  end

endmodule

FILE: design/button_click_press_detector_unit.sv
// Button click / long-press detector.
// Input channel (in_valid / in_stall): one transaction per pin sample, carrying
// the raw pin level, a wrapping millisecond timestamp and a clear request for
// the sticky event code.
// Output channel (out_valid / out_stall): one transaction per input sample,
// carrying the event code after that sample (0 none, 1 click, 2 double,
// 3 triple, 4 long press).
// Configuration: cfg_we / cfg_index / cfg_wdata write the pressed level,
// debounce time, long-press time, click gap and click limit; write only while
// no sample is in flight.
// The sample is registered, then the state machine step and event code land
// in the output register. Throughput is one sample per cycle while the output
// is not stalled.
// A stalled output holds its transaction; the input stage keeps accepting
// until it holds a sample that cannot move, then raises in_stall.
// Reset restores the default configuration, idles the state machine and
// clears the event code; no transactions are pending after reset.
module button_click_press_detector_unit
  import bcpd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_pin_level,
  input  logic [31:0]              in_now_ms,
  input  logic                     in_clear_event,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               out_event_code,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  cfg_t    cfg_r;
  sample_t smp_r;
  logic    smp_valid_r;
  logic    out_valid_r;
  event_t  out_event_r;
  event_t  event_nxt;
  logic    adv;
  logic    in_take;

  // output register is free when empty or being drained
  assign adv      = smp_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = smp_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pressed_level <= 1'b0;
      cfg_r.debounce_ms   <= DEBOUNCE_RST;
      cfg_r.long_press_ms <= LONG_PRESS_RST;
      cfg_r.click_gap_ms  <= CLICK_GAP_RST;
      cfg_r.max_clicks    <= MAX_CLICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRESSED_LEVEL: cfg_r.pressed_level <= cfg_wdata[0];
        CFG_DEBOUNCE_MS:   cfg_r.debounce_ms   <= cfg_wdata;
        CFG_LONG_PRESS_MS: cfg_r.long_press_ms <= cfg_wdata;
        CFG_CLICK_GAP_MS:  cfg_r.click_gap_ms  <= cfg_wdata;
        CFG_MAX_CLICKS:    cfg_r.max_clicks    <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        smp_valid_r <= 1'b1;
      end else if (adv) begin
        smp_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      smp_r.pin_level   <= in_pin_level;
      smp_r.now_ms      <= in_now_ms;
      smp_r.clear_event <= in_clear_event;
    end
    if (adv) begin
      out_event_r <= event_nxt;
    end
  end

  bcpd_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .smp       (smp_r),
    .cfg       (cfg_r),
    .event_nxt (event_nxt)
  );

  assign out_valid      = out_valid_r;
  assign out_event_code = out_event_r;

`ifndef SYNTHESIS
  a_stall_needs_sample: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> smp_valid_r)
    else $error("input stalled with empty sample stage");

  a_out_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r)
    else $error("stalled output transaction dropped");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_event_r == EV_NONE || out_event_r == EV_CLICK ||
                     out_event_r == EV_DOUBLE || out_event_r == EV_TRIPLE ||
                     out_event_r == EV_LONG))
    else $error("event code out of range");

  a_sample_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    smp_valid_r && out_valid_r && out_stall |=> smp_valid_r)
    else $error("sample lost while output stalled");
`endif

endmodule

FILE: test/button_click_press_detector_unit_test.sv
`timescale 1ns / 1ps

module button_click_press_detector_unit_test;
  import bcpd_pkg::*;

  // index past the register list; the block must ignore writes to it
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 3'd7;
  localparam int LONG_HOLD = 400;
  localparam int CYCLE_LIMIT = 800000;
  localparam int DRAIN_CYCLES = 6;

  class detector_scoreboard;
    logic        pressed_level;
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
    logic [15:0] click_gap_ms;
    logic [3:0]  max_clicks;
    state_t      fsm;
    state_t      prev_fsm;
    time_t       start_ms;
    logic [3:0]  clicks;
    event_t      flag;
    event_t      expected_q[$];
    int          errors;

    function new();
      pressed_level = 1'b0;
      debounce_ms = DEBOUNCE_RST;
      long_press_ms = LONG_PRESS_RST;
      click_gap_ms = CLICK_GAP_RST;
      max_clicks = MAX_CLICKS_RST;
      fsm = ST_IDLE;
      prev_fsm = ST_IDLE;
      start_ms = '0;
      clicks = '0;
      flag = EV_NONE;
      errors = 0;
    endfunction

    function void set_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_PRESSED_LEVEL: pressed_level = data[0];
        CFG_DEBOUNCE_MS:   debounce_ms = data;
        CFG_LONG_PRESS_MS: long_press_ms = data;
        CFG_CLICK_GAP_MS:  click_gap_ms = data;
        CFG_MAX_CLICKS:    max_clicks = data[3:0];
        default: ;
      endcase
    endfunction

    function void move_to(state_t nxt);
      prev_fsm = fsm;
      fsm = nxt;
    endfunction

    function void end_burst();
      fsm = ST_IDLE;
      prev_fsm = ST_IDLE;
      clicks = '0;
      start_ms = '0;
    endfunction

    // advance the detector by one pin sample and queue the event code it leaves
    function void note_sample(logic pin, time_t now, logic clr);
      logic  active;
      time_t waited;
      active = (pin == pressed_level);
      waited = now - start_ms;
      if (clr) flag = EV_NONE;
      case (fsm)
        ST_IDLE: if (active) begin
          move_to(ST_DOWN);
          start_ms = now;
          clicks = '0;
        end
        ST_DOWN: begin
          if (!active && waited < TIME_BITS'(debounce_ms)) move_to(prev_fsm);
          else if (!active) begin
            move_to(ST_UP);
            start_ms = now;
          end else if (waited > TIME_BITS'(long_press_ms)) move_to(ST_PRESS);
        end
        ST_UP: begin
          if (active && waited < TIME_BITS'(debounce_ms)) move_to(prev_fsm);
          else if (waited >= TIME_BITS'(debounce_ms)) begin
            clicks = clicks + 4'd1;
            move_to(ST_COUNT);
          end
        end
        ST_COUNT: begin
          if (active) begin
            move_to(ST_DOWN);
            start_ms = now;
          end else if (waited > TIME_BITS'(click_gap_ms) || clicks == max_clicks) begin
            case (clicks)
              4'd1: flag = EV_CLICK;
              4'd2: flag = EV_DOUBLE;
              4'd3: flag = EV_TRIPLE;
              default: ;
            endcase
            end_burst();
          end
        end
        ST_PRESS: if (!active) begin
          move_to(ST_RELEASED);
          start_ms = now;
        end
        ST_RELEASED: begin
          if (active && waited < TIME_BITS'(debounce_ms)) move_to(prev_fsm);
          else if (waited >= TIME_BITS'(debounce_ms)) begin
            flag = EV_LONG;
            end_burst();
          end
        end
        default: move_to(ST_IDLE);
      endcase
      expected_q.push_back(flag);
    endfunction

    function void check_event(logic [2:0] got);
      event_t want;
      if (expected_q.size() == 0) begin
        $error("event_code: no transaction expected, actual %0d", got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          $error("event_code: expected %0d, actual %0d", want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_pin_level = 1'b0;
  logic [31:0]              in_now_ms = '0;
  logic                     in_clear_event = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [2:0]               out_event_code;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  detector_scoreboard board;
  time_t t_ms;
  int    samples_sent = 0;
  int    squeeze_asked = 0;
  int    squeeze_seen = 0;
  int    hold_left = 0;
  int    run_left = 0;
  bit    rx_stalled = 1'b0;
  int    cycles = 0;

  button_click_press_detector_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_pin_level(in_pin_level),
    .in_now_ms(in_now_ms),
    .in_clear_event(in_clear_event),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_event_code(out_event_code),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) pick_len = 0;
    else if (r < 75) pick_len = $urandom_range(1, 3);
    else if (r < 95) pick_len = $urandom_range(4, 12);
    else pick_len = $urandom_range(30, 70);
  endfunction

  function automatic int unsigned pick_span(int unsigned mid);
    case ($urandom_range(0, 5))
      0: pick_span = mid;
      1: pick_span = mid + 1;
      2: pick_span = (mid == 0) ? 0 : mid - 1;
      3: pick_span = $urandom_range(0, mid);
      default: pick_span = mid + $urandom_range(1, mid / 2 + 20);
    endcase
  endfunction

  // receiver: random stalls, plus one long hold-off whenever the sequence asks
  always @(posedge clk) begin
    if (squeeze_seen != squeeze_asked) begin
      squeeze_seen = squeeze_asked;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (run_left == 0) begin
        rx_stalled = !rx_stalled;
        if (rx_stalled) run_left = pick_len() + 1;
        else run_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 30);
      end
      run_left--;
      out_stall <= rx_stalled;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_event(out_event_code);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_sample(logic pin, time_t now, logic clr);
    int idle;
    // keep some stretches gap-free
    idle = (samples_sent % 120 < 25) ? 0 : pick_len();
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pin_level <= pin;
    in_now_ms <= now;
    in_clear_event <= clr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_sample(pin, now, clr);
    samples_sent++;
  endtask

  // hold the pin at the active or inactive level for a span, in a few samples
  task automatic hold_active(logic act, int unsigned span);
    int unsigned n;
    int unsigned step;
    int unsigned i;
    n = $urandom_range(1, 4);
    step = span / n;
    for (i = 0; i < n; i++) begin
      t_ms += (i == n - 1) ? span - step * (n - 1) : step;
      send_sample(act ? board.pressed_level : ~board.pressed_level, t_ms,
                  $urandom_range(0, 5) == 0);
    end
  endtask

  task automatic click_burst(int count);
    int unsigned deb;
    int unsigned lp;
    int unsigned gap;
    deb = 32'(board.debounce_ms);
    lp = 32'(board.long_press_ms);
    gap = 32'(board.click_gap_ms);
    repeat (count) begin
      hold_active(1'b1, (lp > deb) ? $urandom_range(deb, lp) : pick_span(deb));
      hold_active(1'b0, ($urandom_range(0, 3) == 0) ? pick_span(deb)
                                                     : $urandom_range(deb, deb + gap / 2));
    end
    hold_active(1'b0, pick_span(gap + 1));
  endtask

  task automatic run_phase(int items);
    int goal;
    int pick;
    int mc;
    int unsigned mid;
    goal = samples_sent + items;
    while (samples_sent < goal) begin
      pick = $urandom_range(0, 99);
      mc = int'(board.max_clicks);
      if (pick < 40) begin
        // a limit of zero only closes on a wrapped count, so favor sixteen clicks
        if (mc == 0) click_burst($urandom_range(0, 1) ? 16 : $urandom_range(1, 17));
        else click_burst($urandom_range(1, mc + 1));
      end else if (pick < 60) begin
        hold_active(1'b1, pick_span(32'(board.long_press_ms)) +
                          32'(board.debounce_ms) + 1);
        hold_active(1'b0, pick_span(32'(board.debounce_ms)));
      end else if (pick < 72) begin
        repeat ($urandom_range(2, 6))
          hold_active(1'($urandom_range(0, 1)),
                      $urandom_range(0, 32'(board.debounce_ms)));
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 2))
            0: mid = 32'(board.debounce_ms);
            1: mid = 32'(board.long_press_ms);
            default: mid = 32'(board.click_gap_ms);
          endcase
          hold_active(1'($urandom_range(0, 1)), pick_span(mid));
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          t_ms = ($urandom_range(0, 3) == 0) ? $urandom : t_ms + $urandom_range(0, 100);
          send_sample(1'($urandom_range(0, 1)), t_ms, 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    board.set_register(idx, data);
  endtask

  task automatic program_registers(logic pl, logic [15:0] deb, logic [15:0] lp,
                                   logic [15:0] gap, logic [3:0] mc);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_reg(CFG_SPARE, junk);
    junk = 16'($urandom);
    // upper bits of the narrow registers are don't-care
    write_reg(CFG_PRESSED_LEVEL, {junk[15:1], pl});
    write_reg(CFG_DEBOUNCE_MS, deb);
    write_reg(CFG_LONG_PRESS_MS, lp);
    write_reg(CFG_CLICK_GAP_MS, gap);
    junk = 16'($urandom);
    write_reg(CFG_MAX_CLICKS, {junk[15:4], mc});
    cfg_we <= 1'b0;
  endtask

  initial begin
    board = new();
    t_ms = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: pressed is low, debounce 50, long 800, gap 400
    send_sample(1'b1, 32'h0000_0000, 1'b1);
    send_sample(1'b0, 32'hFFFF_FFF0, 1'b0);
    send_sample(1'b1, 32'hFFFF_FFFF, 1'b0);   // bounce across the time wrap
    send_sample(1'b0, 32'd10, 1'b0);
    send_sample(1'b1, 32'd100, 1'b0);
    send_sample(1'b1, 32'd160, 1'b0);
    send_sample(1'b1, 32'd600, 1'b0);         // single click
    send_sample(1'b1, 32'd601, 1'b1);
    send_sample(1'b0, 32'd1000, 1'b0);
    send_sample(1'b0, 32'd1900, 1'b0);
    send_sample(1'b1, 32'd2000, 1'b0);
    send_sample(1'b0, 32'd2010, 1'b0);        // bounce on release of a long press
    send_sample(1'b1, 32'd2020, 1'b0);
    send_sample(1'b1, 32'd2100, 1'b0);        // long press
    send_sample(1'b0, 32'd3000, 1'b0);
    send_sample(1'b1, 32'd3060, 1'b0);
    send_sample(1'b1, 32'd3120, 1'b0);
    send_sample(1'b0, 32'd3130, 1'b0);
    send_sample(1'b1, 32'd3200, 1'b0);
    send_sample(1'b1, 32'd3260, 1'b0);
    send_sample(1'b1, 32'd3700, 1'b1);        // double click with clear in the same step
    t_ms = 32'd4000;
    run_phase(300);
    settle();

    program_registers(1'b1, 16'd10, 16'd200, 16'd100, 4'd2);
    squeeze_asked++;
    run_phase(300);
    settle();

    program_registers(1'b0, 16'd0, 16'd0, 16'd0, 4'd15);
    run_phase(250);
    settle();

    program_registers(1'b1, 16'd5, 16'd1000, 16'd3000, 4'd0);
    t_ms = 32'hFFFF_F000;
    run_phase(300);
    settle();

    program_registers(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd1);
    squeeze_asked++;
    run_phase(200);
    settle();

    program_registers(1'($urandom_range(0, 1)), 16'($urandom_range(0, 200)),
                      16'($urandom_range(0, 2000)), 16'($urandom_range(0, 1000)),
                      4'($urandom_range(1, 15)));
    run_phase(200);
    settle();

    if (board.errors == 0 && board.pending() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

FILE: button_click_press_detector_unit.f
design/bcpd_pkg.sv
design/bcpd_fsm.sv
design/button_click_press_detector_unit.sv
test/button_click_press_detector_unit_test.sv
